@@ sv/gld_pkg.sv @@
// Shared types and constants for the GIF LZW pixel decoder.
`timescale 1ns / 1ps

package gld_pkg;

  localparam int TAB_DEPTH     = 4096;
  localparam int TAB_AW        = 12;
  localparam int MAX_CODE_BITS = 12;
  localparam int TAB_W         = 28;  // prefix 12, first 8, suffix 8

  localparam logic [7:0] CFG_MIN_CODE_SIZE = 8'd0;
  localparam logic [7:0] CFG_FRAME_WIDTH   = 8'd1;
  localparam logic [7:0] CFG_FRAME_HEIGHT  = 8'd2;
  localparam logic [7:0] CFG_INTERLACE_ON  = 8'd3;

  typedef enum logic [3:0] {
    ST_TAKEN   = 4'd0,
    ST_REFUSED = 4'd1,
    ST_PIXEL   = 4'd2,
    ST_DISCARD = 4'd3,
    ST_CLEAR   = 4'd4,
    ST_NEED    = 4'd5,
    ST_END     = 4'd6,
    ST_NOCLEAR = 4'd7,
    ST_BADCODE = 4'd8,
    ST_TOOMANY = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP_ISSUE,
    S_EXP_DATA,
    S_ENTRY,
    S_FINISH,
    S_POP_ADDR,
    S_POP_DATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  min_code_size;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        interlace_on;
  } cfg_t;

endpackage

@@ sv/gld_if.sv @@
// Stream and configuration channel interfaces of the GIF LZW pixel decoder.
`timescale 1ns / 1ps

interface gld_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface gld_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  pixel_index;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  modport source (output valid, status, pixel_index, pixel_x, pixel_y, input ready);
  modport sink   (input valid, status, pixel_index, pixel_x, pixel_y, output ready);
endinterface

interface gld_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/gld_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/gld_core.sv @@
// Decode sequencer: bit unpacking, code table update, chain expansion and pixel placement.
`timescale 1ns / 1ps

module gld_core (
  input  logic                        clk,
  input  logic                        rst,
  input  gld_pkg::cfg_t               cfg_i,
  input  logic                        restart,
  gld_req_if.sink                     req,
  gld_res_if.source                   res,
  // code table memory
  output logic                        tab_we,
  output logic [gld_pkg::TAB_AW-1:0]  tab_waddr,
  output logic [gld_pkg::TAB_W-1:0]   tab_wdata,
  output logic [gld_pkg::TAB_AW-1:0]  tab_raddr,
  input  logic [gld_pkg::TAB_W-1:0]   tab_rdata,
  // expansion stack memory
  output logic                        stk_we,
  output logic [gld_pkg::TAB_AW-1:0]  stk_waddr,
  output logic [7:0]                  stk_wdata,
  output logic [gld_pkg::TAB_AW-1:0]  stk_raddr,
  input  logic [7:0]                  stk_rdata
);

  gld_pkg::state_t state, state_next;

  // decoder state
  logic [19:0] bitbuf, bitbuf_next;
  logic [4:0]  vbc, vbc_next;
  logic [3:0]  cw, cw_next;
  logic [13:0] nfc, nfc_next;
  logic [11:0] prev_code, prev_code_next;
  logic        prev_valid, prev_valid_next;
  logic [7:0]  prev_first, prev_first_next;
  logic        await_clr, await_clr_next;
  logic [7:0]  blk_left, blk_left_next;
  logic [15:0] cur_x, cur_x_next;
  logic [15:0] cur_y, cur_y_next;
  logic [1:0]  pass, pass_next;
  logic [3:0]  rstep, rstep_next;
  logic [3:0]  term, term_next;
  logic        term_valid, term_valid_next;
  logic [12:0] cnt, cnt_next;
  logic [11:0] code_q, code_q_next;
  logic [11:0] chain, chain_next;
  logic [7:0]  root, root_next;
  logic        need_entry, need_entry_next;
  logic        kwk, kwk_next;
  // result staging and output register
  logic [3:0]  p_status, p_status_next;
  logic [7:0]  p_idx, p_idx_next;
  logic [15:0] p_x, p_x_next;
  logic [15:0] p_y, p_y_next;
  logic        ov;
  logic [3:0]  o_status;
  logic [7:0]  o_idx;
  logic [15:0] o_x, o_y;

  // derived values
  logic [3:0]  eff_min;
  logic [11:0] clr;
  logic [11:0] mask;
  logic [11:0] dec_code;
  logic        accept, is_push, is_pull;
  logic        chain_end, out_free;
  logic        grow;

  assign eff_min  = (cfg_i.min_code_size > 4'd11) ? 4'd11 : cfg_i.min_code_size;
  assign clr      = 12'd1 << eff_min;
  assign mask     = 12'((13'd1 << cw) - 13'd1);
  assign dec_code = bitbuf[11:0] & mask;
  assign req.ready = (state == gld_pkg::S_IDLE) && !restart;
  assign accept   = req.valid && req.ready;
  assign is_push  = accept && !req.req_type;
  assign is_pull  = accept && req.req_type;
  assign chain_end = cnt[12] || (chain < clr);
  assign out_free = !ov || res.ready;
  assign grow     = ((nfc[11:0] & mask) == 12'd0) && (nfc <= 14'h0FFF) &&
                    (cw < 4'(gld_pkg::MAX_CODE_BITS));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gld_pkg::S_IDLE: begin
        if (is_push) begin
          state_next = gld_pkg::S_DONE;
        end else if (is_pull) begin
          if (cnt != 13'd0) begin
            state_next = gld_pkg::S_POP_ADDR;
          end else if (term_valid || (5'(cw) > vbc)) begin
            state_next = gld_pkg::S_DONE;
          end else if (dec_code == clr || dec_code == clr + 12'd1 ||
                       14'(dec_code) > nfc || await_clr) begin
            state_next = gld_pkg::S_DONE;
          end else if (prev_valid) begin
            if (nfc[13:12] != 2'd0) begin
              state_next = gld_pkg::S_DONE;
            end else if (14'(dec_code) == nfc) begin
              state_next = gld_pkg::S_ENTRY;
            end else begin
              state_next = gld_pkg::S_EXP_ISSUE;
            end
          end else if (14'(dec_code) == nfc) begin
            state_next = gld_pkg::S_DONE;
          end else begin
            state_next = gld_pkg::S_EXP_ISSUE;
          end
        end
      end
      gld_pkg::S_EXP_ISSUE: begin
        if (chain_end) begin
          state_next = (need_entry && !kwk) ? gld_pkg::S_ENTRY : gld_pkg::S_FINISH;
        end else begin
          state_next = gld_pkg::S_EXP_DATA;
        end
      end
      gld_pkg::S_EXP_DATA: state_next = gld_pkg::S_EXP_ISSUE;
      gld_pkg::S_ENTRY:    state_next = kwk ? gld_pkg::S_EXP_ISSUE : gld_pkg::S_FINISH;
      gld_pkg::S_FINISH:   state_next = gld_pkg::S_POP_DATA;
      gld_pkg::S_POP_ADDR: state_next = gld_pkg::S_POP_DATA;
      gld_pkg::S_POP_DATA: state_next = gld_pkg::S_DONE;
      gld_pkg::S_DONE:     state_next = out_free ? gld_pkg::S_IDLE : gld_pkg::S_DONE;
      default:             state_next = gld_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = nfc[11:0];
    tab_wdata = {prev_code, prev_first, (code_q == nfc[11:0]) ? prev_first : root};
    tab_raddr = chain;
    stk_we    = 1'b0;
    stk_waddr = cnt[11:0];
    stk_wdata = tab_rdata[7:0];
    stk_raddr = 12'(cnt - 13'd1);
    case (state)
      gld_pkg::S_ENTRY: tab_we = 1'b1;
      gld_pkg::S_EXP_ISSUE: begin
        if (!cnt[12] && chain < clr) begin
          stk_we    = 1'b1;
          stk_wdata = chain[7:0];
        end
      end
      gld_pkg::S_EXP_DATA: stk_we = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    logic [16:0] x1, y1;
    logic [15:0] cy;
    logic [3:0]  rs;
    logic [1:0]  ps;
    bitbuf_next     = bitbuf;
    vbc_next        = vbc;
    cw_next         = cw;
    nfc_next        = nfc;
    prev_code_next  = prev_code;
    prev_valid_next = prev_valid;
    prev_first_next = prev_first;
    await_clr_next  = await_clr;
    blk_left_next   = blk_left;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    pass_next       = pass;
    rstep_next      = rstep;
    term_next       = term;
    term_valid_next = term_valid;
    cnt_next        = cnt;
    code_q_next     = code_q;
    chain_next      = chain;
    root_next       = root;
    need_entry_next = need_entry;
    kwk_next        = kwk;
    p_status_next   = p_status;
    p_idx_next      = p_idx;
    p_x_next        = p_x;
    p_y_next        = p_y;

    // cursor advance for a placed pixel
    x1 = {1'b0, cur_x} + 17'd1;
    y1 = {1'b0, cur_y} + 17'(rstep);
    cy = (y1 >= {1'b0, cfg_i.frame_height}) ? cfg_i.frame_height : y1[15:0];
    rs = rstep;
    ps = pass;
    for (int i = 0; i < 3; i++) begin
      if (cy >= cfg_i.frame_height && ps != 2'd0) begin
        rs = 4'd1 << ps;
        cy = 16'(rs >> 1);
        ps = ps - 2'd1;
      end
    end

    case (state)
      gld_pkg::S_IDLE: begin
        if (accept) begin
          p_status_next = gld_pkg::ST_TAKEN;
          p_idx_next    = 8'd0;
          p_x_next      = 16'd0;
          p_y_next      = 16'd0;
        end
        if (is_push) begin
          if (term_valid || vbc >= 5'(cw)) begin
            p_status_next = gld_pkg::ST_REFUSED;
          end else if (blk_left == 8'd0) begin
            if (req.data_byte == 8'd0) begin
              term_next       = gld_pkg::ST_END;
              term_valid_next = 1'b1;
              bitbuf_next     = 20'd0;
              vbc_next        = 5'd0;
            end else begin
              blk_left_next = req.data_byte;
            end
          end else begin
            blk_left_next = blk_left - 8'd1;
            bitbuf_next   = bitbuf | (20'(req.data_byte) << vbc);
            vbc_next      = vbc + 5'd8;
          end
        end else if (is_pull && cnt == 13'd0) begin
          if (term_valid) begin
            p_status_next = term;
          end else if (5'(cw) > vbc) begin
            p_status_next = gld_pkg::ST_NEED;
          end else begin
            // consume one code
            bitbuf_next     = bitbuf >> cw;
            vbc_next        = vbc - 5'(cw);
            code_q_next     = dec_code;
            chain_next      = dec_code;
            cnt_next        = 13'd0;
            need_entry_next = prev_valid;
            kwk_next        = (14'(dec_code) == nfc);
            if (dec_code == clr) begin
              cw_next         = eff_min + 4'd1;
              nfc_next        = 14'(clr) + 14'd2;
              prev_valid_next = 1'b0;
              await_clr_next  = 1'b0;
              p_status_next   = gld_pkg::ST_CLEAR;
            end else if (dec_code == clr + 12'd1) begin
              term_next       = gld_pkg::ST_END;
              term_valid_next = 1'b1;
              p_status_next   = gld_pkg::ST_END;
            end else if (14'(dec_code) > nfc) begin
              term_next       = gld_pkg::ST_BADCODE;
              term_valid_next = 1'b1;
              p_status_next   = gld_pkg::ST_BADCODE;
            end else if (await_clr) begin
              term_next       = gld_pkg::ST_NOCLEAR;
              term_valid_next = 1'b1;
              p_status_next   = gld_pkg::ST_NOCLEAR;
            end else if (prev_valid && nfc[13:12] != 2'd0) begin
              term_next       = gld_pkg::ST_TOOMANY;
              term_valid_next = 1'b1;
              p_status_next   = gld_pkg::ST_TOOMANY;
            end else if (!prev_valid && 14'(dec_code) == nfc) begin
              term_next       = gld_pkg::ST_BADCODE;
              term_valid_next = 1'b1;
              p_status_next   = gld_pkg::ST_BADCODE;
            end
          end
        end
      end
      gld_pkg::S_EXP_ISSUE: begin
        if (!cnt[12] && chain < clr) begin
          cnt_next  = cnt + 13'd1;
          root_next = chain[7:0];
        end
      end
      gld_pkg::S_EXP_DATA: begin
        cnt_next   = cnt + 13'd1;
        chain_next = tab_rdata[27:16];
      end
      gld_pkg::S_ENTRY: begin
        nfc_next = nfc + 14'd1;
      end
      gld_pkg::S_FINISH: begin
        if (grow) begin
          cw_next = cw + 4'd1;
        end
        prev_code_next  = code_q;
        prev_valid_next = 1'b1;
        prev_first_next = root;
      end
      gld_pkg::S_POP_DATA: begin
        cnt_next = cnt - 13'd1;
        if (cur_y >= cfg_i.frame_height) begin
          p_status_next = gld_pkg::ST_DISCARD;
        end else begin
          p_status_next = gld_pkg::ST_PIXEL;
          p_idx_next    = stk_rdata;
          p_x_next      = cur_x;
          p_y_next      = cur_y;
          if (x1 >= {1'b0, cfg_i.frame_width}) begin
            cur_x_next = 16'd0;
            cur_y_next = cy;
            rstep_next = rs;
            pass_next  = ps;
          end else begin
            cur_x_next = x1[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gld_pkg::S_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gld_pkg::S_DONE && out_free) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // decoder state, restart loads the post-reset values
  always_ff @(posedge clk) begin
    if (restart) begin
      bitbuf     <= 20'd0;
      vbc        <= 5'd0;
      cw         <= eff_min + 4'd1;
      nfc        <= 14'(clr) + 14'd2;
      prev_valid <= 1'b0;
      await_clr  <= 1'b1;
      blk_left   <= 8'd0;
      cur_x      <= 16'd0;
      cur_y      <= (cfg_i.frame_width == 16'd0) ? cfg_i.frame_height : 16'd0;
      pass       <= cfg_i.interlace_on ? 2'd3 : 2'd0;
      rstep      <= cfg_i.interlace_on ? 4'd8 : 4'd1;
      term_valid <= 1'b0;
      cnt        <= 13'd0;
    end else begin
      bitbuf     <= bitbuf_next;
      vbc        <= vbc_next;
      cw         <= cw_next;
      nfc        <= nfc_next;
      prev_valid <= prev_valid_next;
      await_clr  <= await_clr_next;
      blk_left   <= blk_left_next;
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      pass       <= pass_next;
      rstep      <= rstep_next;
      term_valid <= term_valid_next;
      cnt        <= cnt_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_code  <= prev_code_next;
    prev_first <= prev_first_next;
    term       <= term_next;
    code_q     <= code_q_next;
    chain      <= chain_next;
    root       <= root_next;
    need_entry <= need_entry_next;
    kwk        <= kwk_next;
    p_status   <= p_status_next;
    p_idx      <= p_idx_next;
    p_x        <= p_x_next;
    p_y        <= p_y_next;
    if (state == gld_pkg::S_DONE && out_free) begin
      o_status <= p_status;
      o_idx    <= p_idx;
      o_x      <= p_x;
      o_y      <= p_y;
    end
  end

  assign res.valid       = ov;
  assign res.status      = o_status;
  assign res.pixel_index = o_idx;
  assign res.pixel_x     = o_x;
  assign res.pixel_y     = o_y;

`ifndef SYNTH
  // a code never needs more bits than the buffer holds
  a_vbc_range: assert property (@(posedge clk) disable iff (rst || restart)
    vbc <= 5'd19) else $error("bit count out of range");
  // code width stays within one and twelve bits
  a_cw_range: assert property (@(posedge clk) disable iff (rst || restart)
    (cw >= 4'd1) && (cw <= 4'(gld_pkg::MAX_CODE_BITS))) else $error("code width out of range");
  // expansion stack never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst || restart)
    cnt <= 13'(gld_pkg::TAB_DEPTH)) else $error("stack count out of range");
  // a placed pixel lies inside the frame
  a_pix_inside: assert property (@(posedge clk) disable iff (rst || restart)
    (state == gld_pkg::S_POP_DATA && cur_y < cfg_i.frame_height) |=>
    (p_status == gld_pkg::ST_PIXEL) && (p_y < cfg_i.frame_height))
    else $error("pixel placed outside frame");
`endif

endmodule

@@ sv/gif_lzw_pixel_decoder.sv @@
// GIF LZW pixel decoder top level: configuration registers, table and stack memories.
`timescale 1ns / 1ps

// Each request transaction gives exactly one result, and the next request is taken only once
// the block is back in its idle state. A push, and a pull that returns a clear, end, error or
// need-data status, goes from taking the request straight to presenting the result. A pull
// that pops an already expanded pixel goes through take, stack read, pixel placement, result.
// A pull that decodes a data code goes through take, a table read then a stack write for each
// non-root link of the prefix chain, the root, the table entry write, the stack read, pixel
// placement and the result. The first code after a clear code writes no entry. A stalled
// result holds the block for as long as the stall lasts. A write to one of the four
// configuration registers restarts decoding; the restart register is set in the cycle after
// the write, and no request is taken while it is set. Table entries are never cleared: only
// entries written since the last clear code are read.
module gif_lzw_pixel_decoder (
  input  logic      clk,
  input  logic      rst,
  gld_req_if.sink   req,
  gld_res_if.source res,
  gld_cfg_if.sink   cfg
);

  gld_pkg::cfg_t cfg_q;
  logic          restart_q;

  logic                       tab_we, stk_we;
  logic [gld_pkg::TAB_AW-1:0] tab_waddr, tab_raddr, stk_waddr, stk_raddr;
  logic [gld_pkg::TAB_W-1:0]  tab_wdata, tab_rdata;
  logic [7:0]                 stk_wdata, stk_rdata;

  assign cfg.ready = 1'b1;

  // configuration registers, a write to any of the four registers restarts decoding
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.min_code_size <= 4'd8;
      cfg_q.frame_width   <= 16'd0;
      cfg_q.frame_height  <= 16'd0;
      cfg_q.interlace_on  <= 1'b0;
      restart_q           <= 1'b1;
    end else begin
      restart_q <= 1'b0;
      if (cfg.valid) begin
        case (cfg.index)
          gld_pkg::CFG_MIN_CODE_SIZE: begin
            cfg_q.min_code_size <= cfg.data[3:0];
            restart_q           <= 1'b1;
          end
          gld_pkg::CFG_FRAME_WIDTH: begin
            cfg_q.frame_width <= cfg.data;
            restart_q         <= 1'b1;
          end
          gld_pkg::CFG_FRAME_HEIGHT: begin
            cfg_q.frame_height <= cfg.data;
            restart_q          <= 1'b1;
          end
          gld_pkg::CFG_INTERLACE_ON: begin
            cfg_q.interlace_on <= cfg.data[0];
            restart_q          <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  gld_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_i     (cfg_q),
    .restart   (restart_q),
    .req       (req),
    .res       (res),
    .tab_we    (tab_we),
    .tab_waddr (tab_waddr),
    .tab_wdata (tab_wdata),
    .tab_raddr (tab_raddr),
    .tab_rdata (tab_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // code table: prefix, first and suffix of each entry
  gld_ram #(.WIDTH(gld_pkg::TAB_W), .DEPTH(gld_pkg::TAB_DEPTH)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // expansion stack
  gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::TAB_DEPTH)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the GIF LZW pixel decoder: stream generator, predictor, checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_ITEMS  = 400;

  typedef struct packed {
    gld_pkg::status_t status;
    logic [7:0]       index;
    logic [15:0]      x;
    logic [15:0]      y;
  } pix_res_t;

  typedef struct packed {
    logic       pull;
    logic [7:0] data;
  } stream_req_t;

  logic clk = 1'b0;
  logic rst;

  gld_req_if req_ch ();
  gld_res_if res_ch ();
  gld_cfg_if cfg_ch ();

  gif_lzw_pixel_decoder DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  stream_req_t pending_reqs[$];
  pix_res_t    expected_pix[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rand_items = 0;
  bit          calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder predictor
  // ---------------------------------------------------------------------------
  logic [3:0]  m_min_size;
  logic [15:0] m_fw, m_fh;
  logic        m_ilace;

  logic [12:0] tab_prefix[gld_pkg::TAB_DEPTH];
  logic [7:0]  tab_first[gld_pkg::TAB_DEPTH];
  logic [7:0]  tab_suffix[gld_pkg::TAB_DEPTH];
  logic [7:0]  pix_stack[gld_pkg::TAB_DEPTH];
  int unsigned stk_n, bitbuf, nbits, cwidth, nfree, prev_code;
  bit          prev_ok, want_clear, term_set;
  gld_pkg::status_t term;
  int unsigned blk_left, cur_x, cur_y, ipass, rstep;

  function automatic int unsigned eff_min();
    return (m_min_size > gld_pkg::MAX_CODE_BITS - 1) ? gld_pkg::MAX_CODE_BITS - 1 : m_min_size;
  endfunction

  function automatic void decoder_restart();
    for (int i = 0; i < gld_pkg::TAB_DEPTH; i++) begin
      tab_prefix[i] = '0;
      tab_first[i]  = '0;
      tab_suffix[i] = '0;
      pix_stack[i]  = '0;
    end
    stk_n      = 0;
    bitbuf     = 0;
    nbits      = 0;
    cwidth     = eff_min() + 1;
    nfree      = (1 << eff_min()) + 2;
    prev_code  = 0;
    prev_ok    = 1'b0;
    want_clear = 1'b1;
    blk_left   = 0;
    cur_x      = 0;
    cur_y      = (m_fw == 0) ? m_fh : 0;
    ipass      = m_ilace ? 3 : 0;
    rstep      = m_ilace ? 8 : 1;
    term_set   = 1'b0;
    term       = gld_pkg::ST_TAKEN;
  endfunction

  function automatic logic [7:0] first_sym(int unsigned c, int unsigned clr);
    return (c < clr) ? c[7:0] : tab_first[c[11:0]];
  endfunction

  // Walk the prefix chain, pushing suffixes so the first symbol ends on top.
  function automatic void expand_chain(int unsigned c, int unsigned clr);
    int unsigned guard;
    guard = 0;
    stk_n = 0;
    while (guard < gld_pkg::TAB_DEPTH && stk_n < gld_pkg::TAB_DEPTH) begin
      c &= gld_pkg::TAB_DEPTH - 1;
      if (c < clr) begin
        pix_stack[stk_n] = c[7:0];
        stk_n++;
        return;
      end
      pix_stack[stk_n] = tab_suffix[c];
      stk_n++;
      c = tab_prefix[c];
      guard++;
    end
  endfunction

  function automatic void pop_pix(inout pix_res_t r);
    logic [7:0]  idx;
    int unsigned ny;
    idx = pix_stack[(stk_n - 1) & (gld_pkg::TAB_DEPTH - 1)];
    stk_n--;
    if (cur_y >= m_fh) begin
      r.status = gld_pkg::ST_DISCARD;
      return;
    end
    r.status = gld_pkg::ST_PIXEL;
    r.index  = idx;
    r.x      = cur_x[15:0];
    r.y      = cur_y[15:0];
    cur_x++;
    if (cur_x >= m_fw) begin
      ny    = cur_y + rstep;
      cur_x = 0;
      cur_y = (ny >= m_fh) ? m_fh : ny;
      // interlace: move on to the next pass once the rows run out
      while (cur_y >= m_fh && ipass > 0) begin
        rstep = 1 << ipass;
        cur_y = rstep >> 1;
        ipass--;
      end
    end
  endfunction

  function automatic void set_term(gld_pkg::status_t s, inout pix_res_t r);
    term     = s;
    term_set = 1'b1;
    r.status = s;
  endfunction

  function automatic void decode_one(inout pix_res_t r);
    int unsigned clr, mask, code, slot, f;
    clr    = 1 << eff_min();
    mask   = (1 << cwidth) - 1;
    code   = bitbuf & mask;
    bitbuf = bitbuf >> cwidth;
    nbits  = nbits - cwidth;
    if (code == clr) begin
      cwidth     = eff_min() + 1;
      nfree      = clr + 2;
      prev_ok    = 1'b0;
      want_clear = 1'b0;
      r.status   = gld_pkg::ST_CLEAR;
      return;
    end
    if (code == clr + 1) begin
      set_term(gld_pkg::ST_END, r);
      return;
    end
    if (code > nfree) begin
      set_term(gld_pkg::ST_BADCODE, r);
      return;
    end
    if (want_clear) begin
      set_term(gld_pkg::ST_NOCLEAR, r);
      return;
    end
    if (prev_ok) begin
      slot = nfree;
      if (slot >= gld_pkg::TAB_DEPTH) begin
        set_term(gld_pkg::ST_TOOMANY, r);
        return;
      end
      f                = first_sym(prev_code, clr);
      tab_prefix[slot] = prev_code[12:0];
      tab_first[slot]  = f[7:0];
      tab_suffix[slot] = (code == slot) ? f[7:0] : first_sym(code, clr);
      nfree            = slot + 1;
    end else if (code == nfree) begin
      // repeat-last-string code with nothing before it
      set_term(gld_pkg::ST_BADCODE, r);
      return;
    end
    expand_chain(code, clr);
    if ((nfree & mask) == 0 && nfree <= 'h0FFF && cwidth < gld_pkg::MAX_CODE_BITS) cwidth++;
    prev_code = code;
    prev_ok   = 1'b1;
    pop_pix(r);
  endfunction

  function automatic pix_res_t predict_step(logic pull, logic [7:0] b);
    pix_res_t r;
    r = '0;
    r.status = gld_pkg::ST_TAKEN;
    if (!pull) begin
      if (term_set || nbits >= cwidth) begin
        r.status = gld_pkg::ST_REFUSED;
      end else if (blk_left == 0) begin
        if (b == 8'd0) begin
          term     = gld_pkg::ST_END;
          term_set = 1'b1;
          bitbuf   = 0;
          nbits    = 0;
        end else begin
          blk_left = b;
        end
      end else begin
        blk_left--;
        bitbuf = (bitbuf | (int'(b) << nbits)) & 'hFFFFF;
        nbits += 8;
      end
      return r;
    end
    if (stk_n > 0) pop_pix(r);
    else if (term_set) r.status = term;
    else if (nbits >= cwidth) decode_one(r);
    else r.status = gld_pkg::ST_NEED;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Code stream generator: tracks the decoder's table size and code width
  // ---------------------------------------------------------------------------
  localparam int MODE_NORMAL  = 0;
  localparam int MODE_NOCLEAR = 1;
  localparam int MODE_FILL    = 2;
  localparam int MODE_BAD     = 3;
  localparam int MODE_NOISE   = 4;
  localparam int MODE_CUT     = 5;

  int unsigned e_eff, e_clr, e_width, e_nf;
  bit          e_pv;
  longint unsigned bit_acc;
  int unsigned bit_cnt;
  logic [7:0]  code_bytes[$];
  logic [7:0]  stream_bytes[$];

  function automatic void gen_restart(int unsigned mcs);
    e_eff    = (mcs > gld_pkg::MAX_CODE_BITS - 1) ? gld_pkg::MAX_CODE_BITS - 1 : mcs;
    e_clr    = 1 << e_eff;
    e_width  = e_eff + 1;
    e_nf     = e_clr + 2;
    e_pv     = 1'b0;
    bit_acc  = 0;
    bit_cnt  = 0;
    code_bytes.delete();
  endfunction

  // Pack one code LSB first, then follow the decoder's table growth.
  function automatic void put_code(int unsigned code);
    int unsigned mask;
    bit_acc |= longint'(code) << bit_cnt;
    bit_cnt += e_width;
    while (bit_cnt >= 8) begin
      code_bytes.push_back(bit_acc[7:0]);
      bit_acc >>= 8;
      bit_cnt -= 8;
    end
    mask = (1 << e_width) - 1;
    if (code == e_clr) begin
      e_width = e_eff + 1;
      e_nf    = e_clr + 2;
      e_pv    = 1'b0;
      return;
    end
    if (code == e_clr + 1) return;
    if (e_pv) e_nf++;
    if ((e_nf & mask) == 0 && e_nf <= 'h0FFF && e_width < gld_pkg::MAX_CODE_BITS) e_width++;
    e_pv = 1'b1;
  endfunction

  function automatic int unsigned pick_code();
    int unsigned r, lim, hi;
    r   = $urandom_range(0, 99);
    lim = 1 << e_width;
    if (e_pv && e_nf >= gld_pkg::TAB_DEPTH) return e_clr;
    if (r < 4) return e_clr;
    if (!e_pv || r < 50) return $urandom_range(0, e_clr - 1);
    if (r < 80) begin
      hi = (e_nf - 1 < lim - 1) ? e_nf - 1 : lim - 1;
      if (e_nf > e_clr + 2 && hi >= e_clr + 2) return $urandom_range(e_clr + 2, hi);
    end
    if (e_nf < lim) return e_nf;
    return $urandom_range(0, e_clr - 1);
  endfunction

  // Wrap the packed codes into length-prefixed sub-blocks ending in a zero length.
  function automatic void make_blocks(bit cut_early);
    int unsigned pos, len, nblk;
    stream_bytes.delete();
    pos  = 0;
    nblk = 0;
    while (pos < code_bytes.size()) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
      if (len > code_bytes.size() - pos) len = code_bytes.size() - pos;
      if (cut_early && nblk > 0 && $urandom_range(0, 1)) begin
        // partial sub-block, then the terminator lands where data is due
        len = $urandom_range(1, len);
        stream_bytes.push_back(8'(len + 1));
        for (int i = 0; i < len; i++) stream_bytes.push_back(code_bytes[pos + i]);
        break;
      end
      stream_bytes.push_back(8'(len));
      for (int i = 0; i < len; i++) stream_bytes.push_back(code_bytes[pos + i]);
      pos += len;
      nblk++;
      if (cut_early && nblk > 1) break;
    end
    stream_bytes.push_back(8'd0);
  endfunction

  function automatic void build_stream(int mode, int unsigned ncodes, int unsigned mcs);
    int unsigned n;
    gen_restart(mcs);
    if (mode == MODE_NOISE) begin
      stream_bytes.delete();
      n = $urandom_range(4, 40);
      for (int i = 0; i < n; i++) stream_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1)) stream_bytes.push_back(8'd0);
      return;
    end
    if (mode != MODE_NOCLEAR) put_code(e_clr);
    for (int unsigned i = 0; i < ncodes; i++) begin
      if (mode == MODE_FILL) begin
        // roots only until the table is full, then one more data code
        put_code($urandom_range(0, e_clr - 1));
        if (e_pv && e_nf >= gld_pkg::TAB_DEPTH) begin
          put_code($urandom_range(0, e_clr - 1));
          break;
        end
      end else if (mode == MODE_BAD && i == ncodes - 1) begin
        put_code(e_clr);
        if (e_clr >= 4 && $urandom_range(0, 1)) put_code(e_clr + 3);
        else put_code(e_clr + 2);
      end else begin
        put_code(pick_code());
      end
    end
    if (mode != MODE_FILL && $urandom_range(0, 3) != 0) put_code(e_clr + 1);
    if (bit_cnt > 0) code_bytes.push_back(8'((bit_acc | (longint'($urandom) << bit_cnt)) & 'hFF));
    make_blocks(mode == MODE_CUT);
  endfunction

  // ---------------------------------------------------------------------------
  // Queue one request transaction together with its predicted result
  // ---------------------------------------------------------------------------
  function automatic void queue_req(logic pull, logic [7:0] b);
    stream_req_t q;
    q.pull = pull;
    q.data = pull ? 8'($urandom) : b;
    pending_reqs.push_back(q);
    expected_pix.push_back(predict_step(q.pull, q.data));
    rand_items++;
  endfunction

  // Push the stream, pulling whenever the decoder holds a full code.
  function automatic void feed_stream();
    int unsigned j, guard;
    j     = 0;
    guard = 0;
    while (j < stream_bytes.size() && guard < 200000) begin
      guard++;
      if (term_set) begin
        queue_req(1'b0, stream_bytes[j]);
        break;
      end
      if (nbits >= cwidth || (stk_n > 0 && $urandom_range(0, 1))) queue_req(1'b1, 8'd0);
      else if ($urandom_range(0, 5) == 0) queue_req(1'b1, 8'd0);
      else begin
        queue_req(1'b0, stream_bytes[j]);
        j++;
      end
    end
    // drain what can still be decoded; a stream cut short just runs out of bits
    while ((stk_n > 0 || (!term_set && nbits >= cwidth)) && guard < 400000) begin
      guard++;
      queue_req(1'b1, 8'd0);
    end
    queue_req(1'b1, 8'd0);
    queue_req(1'b0, 8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  bit          req_fire;
  int unsigned req_gap = 0;

  always @(posedge clk) req_fire <= req_ch.valid && req_ch.ready;

  always @(negedge clk) begin
    stream_req_t q;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fire) begin
      // hold the transaction until it is taken
    end else if (req_gap > 0) begin
      req_gap--;
      req_ch.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      req_gap = $urandom_range(0, 4);
      req_ch.valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      q = pending_reqs.pop_front();
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= q.pull;
      req_ch.data_byte <= q.data;
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and checker
  // ---------------------------------------------------------------------------
  int unsigned res_gap = 0;

  task automatic report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, exp_v, got_v, cycle_count);
    err_count++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      res_gap = $urandom_range(0, 4);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pix_res_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_pix.size() == 0) begin
        report_mismatch("unexpected result, status", 0, res_ch.status);
      end else begin
        e = expected_pix.pop_front();
        if (res_ch.status !== e.status) report_mismatch("status", e.status, res_ch.status);
        if (res_ch.pixel_index !== e.index) report_mismatch("pixel_index", e.index, res_ch.pixel_index);
        if (res_ch.pixel_x !== e.x) report_mismatch("pixel_x", e.x, res_ch.pixel_x);
        if (res_ch.pixel_y !== e.y) report_mismatch("pixel_y", e.y, res_ch.pixel_y);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes and sequencing
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() > 0 || req_ch.valid || expected_pix.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 16'($urandom);
    case (idx)
      gld_pkg::CFG_MIN_CODE_SIZE: m_min_size = val[3:0];
      gld_pkg::CFG_FRAME_WIDTH:   m_fw       = val;
      gld_pkg::CFG_FRAME_HEIGHT:  m_fh       = val;
      default:                    m_ilace    = val[0];
    endcase
    decoder_restart();
  endtask

  task automatic set_frame(int unsigned mcs, int unsigned fw, int unsigned fh, bit il);
    wait_idle();
    write_reg(gld_pkg::CFG_MIN_CODE_SIZE, 16'(mcs));
    write_reg(gld_pkg::CFG_FRAME_WIDTH, 16'(fw));
    write_reg(gld_pkg::CFG_FRAME_HEIGHT, 16'(fh));
    write_reg(gld_pkg::CFG_INTERLACE_ON, 16'(il));
  endtask

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 16'hFFFF;
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return MODE_NORMAL;
    if (r < 63) return MODE_NOCLEAR;
    if (r < 73) return MODE_BAD;
    if (r < 85) return MODE_NOISE;
    return MODE_CUT;
  endfunction

  initial begin
    int unsigned sess;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = 1'b0;
    req_ch.data_byte = 8'd0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = 8'd0;
    cfg_ch.data      = 16'd0;
    m_min_size = 4'd8;
    m_fw       = 16'd0;
    m_fh       = 16'd0;
    m_ilace    = 1'b0;
    decoder_restart();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pull on empty input, then clear, roots, a repeat-last-string code,
    // pixels past the frame end, end code, and traffic after the end.
    queue_req(1'b1, 8'd0);
    wait_idle();
    set_frame(2, 3, 1, 1'b0);
    gen_restart(2);
    put_code(e_clr);
    put_code(1);
    put_code(e_nf);
    put_code(3);
    put_code(e_clr + 1);
    if (bit_cnt > 0) code_bytes.push_back(bit_acc[7:0]);
    stream_bytes.delete();
    stream_bytes.push_back(8'(code_bytes.size()));
    foreach (code_bytes[i]) stream_bytes.push_back(code_bytes[i]);
    stream_bytes.push_back(8'd0);
    feed_stream();
    rand_items = 0;

    // Fixed corner settings first, then random ones.
    sess = 0;
    while (rand_items < RAND_ITEMS) begin
      case (sess)
        0: set_frame(15, 16'hFFFF, 16'hFFFF, 1'b0);
        1: set_frame(0, 0, 5, 1'b1);
        2: set_frame(1, 3, 20, 1'b1);
        3: set_frame(12, 1, 1, 1'b0);
        4: set_frame(8, 5, 16'hFFFF, 1'b1);
        default: set_frame($urandom_range(0, 15), pick_dim(), pick_dim(), 1'($urandom));
      endcase
      build_stream((sess < 5) ? MODE_NORMAL : pick_mode(), $urandom_range(5, 60), m_min_size);
      feed_stream();
      sess++;
    end

    // Closing stretch with no idling on either side.
    wait_idle();
    calm = 1'b1;
    for (int i = 0; i < 3; i++) begin
      set_frame($urandom_range(2, 8), $urandom_range(1, 9), $urandom_range(1, 9), 1'($urandom));
      build_stream(MODE_NORMAL, $urandom_range(8, 20), m_min_size);
      feed_stream();
    end
    wait_idle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ gif_lzw_pixel_decoder.f @@
sv/gld_pkg.sv
sv/gld_if.sv
sv/gld_ram.sv
sv/gld_core.sv
sv/gif_lzw_pixel_decoder.sv
test/tb_top.sv
